>>> design/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue: command and status
// codes, request/response payloads and the per-cell operation.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEPTH_DEF       = 16;
	localparam int ENTRY_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_REMOVE_AT  = 3'd4,
		CMD_CLEAR      = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// The operation that every cell of the row carries out
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_REMOVE
	} cell_op_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] entry_value;
		logic [4:0]  position;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] front_value;
		logic [31:0] back_value;
		logic [4:0]  count;
	} rsp_t;

endpackage

>>> design/double_ended_queue.sv
// One command per clock while the response is not stalled: push-front,
// pop-front and remove-at shift the row of DEPTH cells, push-back writes a
// single cell and pop-back and clear change only the count. The response is
// registered in the next cycle. A stalled response holds the request side
// only until it is taken in the same cycle. The front entry is cell 0 and
// the back entry comes from the cell matching the fill count. Storage needs
// no clearing after reset; unused command codes answer ok and change nothing.
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue built as a shifting row of cells.
// ----------------------------------------------------------------------------
module double_ended_queue #(
	parameter int DEPTH       = deq_pkg::DEPTH_DEF,
	parameter int ENTRY_WIDTH = deq_pkg::ENTRY_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  deq_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output deq_pkg::rsp_t  rsp
);
	import deq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	cell_op_t               op;
	logic [CW-1:0]          sel_idx;
	logic [CW-1:0]          count;
	status_t                status;
	logic [ENTRY_WIDTH-1:0] push_value;
	logic [ENTRY_WIDTH-1:0] cell_data [DEPTH];
	logic [ENTRY_WIDTH-1:0] tail_data [DEPTH];
	logic [ENTRY_WIDTH-1:0] front_e;
	logic [ENTRY_WIDTH-1:0] back_e;

	assign push_value = ENTRY_WIDTH'(req.entry_value);

	deq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cmd       (req.cmd),
		.position  (req.position),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.op        (op),
		.sel_idx   (sel_idx),
		.count     (count),
		.status    (status)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ENTRY_WIDTH-1:0] left_in;
		logic [ENTRY_WIDTH-1:0] right_in;

		if (i == 0) begin : g_head
			assign left_in = push_value;
		end else begin : g_body
			assign left_in = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_in = cell_data[i];
		end else begin : g_inner
			assign right_in = cell_data[i+1];
		end

		deq_cell #(
			.DEPTH       (DEPTH),
			.ENTRY_WIDTH (ENTRY_WIDTH),
			.INDEX       (i)
		) u_cell (
			.clk        (clk),
			.op         (op),
			.sel_idx    (sel_idx),
			.count      (count),
			.push_value (push_value),
			.left_data  (left_in),
			.right_data (right_in),
			.data       (cell_data[i]),
			.tail_data  (tail_data[i])
		);
	end

	// only the tail cell drives a nonzero word
	always_comb begin
		back_e = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_e = back_e | tail_data[i];
		end
	end

	assign front_e = (count != '0) ? cell_data[0] : '0;

	assign rsp.status      = status;
	assign rsp.front_value = 32'(front_e);
	assign rsp.back_value  = 32'(back_e);
	assign rsp.count       = 5'(count);

endmodule

>>> design/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the queue row. Takes the new entry, its left or right
// neighbor, or holds, as the broadcast operation and its own place decide.
// ----------------------------------------------------------------------------
module deq_cell #(
	parameter int DEPTH       = deq_pkg::DEPTH_DEF,
	parameter int ENTRY_WIDTH = deq_pkg::ENTRY_WIDTH_DEF,
	parameter int INDEX       = 0
) (
	input  logic                               clk,
	input  deq_pkg::cell_op_t                  op,
	input  logic [$clog2(DEPTH+1)-1:0]         sel_idx,
	input  logic [$clog2(DEPTH+1)-1:0]         count,
	input  logic [ENTRY_WIDTH-1:0]             push_value,
	input  logic [ENTRY_WIDTH-1:0]             left_data,
	input  logic [ENTRY_WIDTH-1:0]             right_data,
	output logic [ENTRY_WIDTH-1:0]             data,
	output logic [ENTRY_WIDTH-1:0]             tail_data
);
	import deq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic [ENTRY_WIDTH-1:0] data_q;
	logic [ENTRY_WIDTH-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (op)
			OP_PUSH_FRONT: begin
				data_d = (INDEX == 0) ? push_value : left_data;
			end
			OP_PUSH_BACK: begin
				if (sel_idx == CW'(INDEX)) data_d = push_value;
			end
			OP_POP_FRONT: begin
				data_d = right_data;
			end
			OP_REMOVE: begin
				// every cell at or behind the removed slot closes the gap
				if (sel_idx <= CW'(INDEX)) data_d = right_data;
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data      = data_q;
	assign tail_data = (count == CW'(INDEX + 1)) ? data_q : '0;

endmodule

>>> design/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Handshake, fill count and status of the queue. Decodes each request into
// one operation for the cell row.
// ----------------------------------------------------------------------------
module deq_ctrl #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  deq_pkg::cmd_t               cmd,
	input  logic [4:0]                  position,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output deq_pkg::cell_op_t           op,
	output logic [$clog2(DEPTH+1)-1:0]  sel_idx,
	output logic [$clog2(DEPTH+1)-1:0]  count,
	output deq_pkg::status_t            status
);
	import deq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic          rsp_valid_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	status_t       status_q;
	status_t       status_d;
	cell_op_t      op_d;
	logic          accept;
	logic          is_full;
	logic          is_empty;
	logic          pos_bad;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign is_full   = (count_q == CW'(DEPTH));
	assign is_empty  = (count_q == '0);
	assign pos_bad   = (position == 5'd0) || (32'(position) > 32'(count_q));

	always_comb begin
		status_d = ST_OK;
		op_d     = OP_HOLD;
		count_d  = count_q;
		sel_idx  = count_q;
		case (cmd)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					op_d    = (cmd == CMD_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
					count_d = count_q + 1'b1;
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					op_d    = (cmd == CMD_POP_FRONT) ? OP_POP_FRONT : OP_HOLD;
					count_d = count_q - 1'b1;
				end
			end
			CMD_REMOVE_AT: begin
				sel_idx = CW'(32'(position) - 32'd1);
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else if (pos_bad) begin
					status_d = ST_NOT_FOUND;
				end else begin
					op_d    = OP_REMOVE;
					count_d = count_q - 1'b1;
				end
			end
			CMD_CLEAR: begin
				count_d = '0;
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
		if (!accept) op_d = OP_HOLD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (accept) begin
				rsp_valid_q <= 1'b1;
				count_q     <= count_d;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) status_q <= status_d;
	end

	assign op        = op_d;
	assign count     = count_q;
	assign status    = status_q;
	assign rsp_valid = rsp_valid_q;

endmodule

>>> design/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks of the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input deq_pkg::rsp_t rsp
);
	import deq_pkg::*;

	// a stalled response keeps its contents
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// every accepted request yields a response next cycle
	a_req_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("accepted request without response");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.count == 5'(DEPTH))
		else $error("full reported below depth");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_EMPTY |-> rsp.count == 5'd0)
		else $error("empty reported with entries held");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.count == 5'd0 && DEPTH < 32 |->
			rsp.front_value == 32'd0 && rsp.back_value == 32'd0)
		else $error("empty queue shows nonzero entries");

endmodule

bind double_ended_queue deq_checker #(
	.DEPTH (DEPTH)
) u_deq_checker (.*);

>>> test/deq_response_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deq_response_checker
// Watches both channels of the double-ended queue. It keeps a shadow copy of
// the held entries, works out the answer to every accepted request and
// compares each accepted response against the oldest answer still owed.
// ----------------------------------------------------------------------------
module deq_response_checker #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_ready,
	input  deq_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  deq_pkg::rsp_t rsp,
	output int            mismatches,
	output int            answers_owed
);
	import deq_pkg::*;

	logic [31:0] held_entries[$];
	rsp_t        owed_answers[$];

	// Applies one request to the shadow queue and returns the answer it gives
	function automatic rsp_t apply_command(req_t r);
		rsp_t answer;
		answer.status = ST_OK;
		case (r.cmd)
			CMD_PUSH_FRONT: begin
				if (held_entries.size() >= DEPTH)
					answer.status = ST_FULL;
				else
					held_entries.push_front(r.entry_value);
			end
			CMD_PUSH_BACK: begin
				if (held_entries.size() >= DEPTH)
					answer.status = ST_FULL;
				else
					held_entries.push_back(r.entry_value);
			end
			CMD_POP_FRONT: begin
				if (held_entries.size() == 0)
					answer.status = ST_EMPTY;
				else
					void'(held_entries.pop_front());
			end
			CMD_POP_BACK: begin
				if (held_entries.size() == 0)
					answer.status = ST_EMPTY;
				else
					void'(held_entries.pop_back());
			end
			CMD_REMOVE_AT: begin
				if (held_entries.size() == 0)
					answer.status = ST_EMPTY;
				else if (r.position == 0 || r.position > held_entries.size())
					answer.status = ST_NOT_FOUND;
				else
					held_entries.delete(r.position - 1);
			end
			CMD_CLEAR: begin
				held_entries.delete();
			end
			default: begin
				// spare codes change nothing
			end
		endcase
		if (held_entries.size() == 0) begin
			answer.front_value = '0;
			answer.back_value  = '0;
		end else begin
			answer.front_value = held_entries[0];
			answer.back_value  = held_entries[$];
		end
		answer.count = 5'(held_entries.size());
		return answer;
	endfunction

	function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		int   bad;
		if (!arst_n) begin
			mismatches   <= 0;
			answers_owed <= 0;
		end else begin
			bad = 0;
			if (rsp_valid && rsp_ready) begin
				if (owed_answers.size() == 0) begin
					$display("%0t: response with no request outstanding, expected none, got %h",
						$time, rsp);
					bad = 1;
				end else begin
					want = owed_answers.pop_front();
					bad += field_differs("status", want.status, rsp.status);
					bad += field_differs("front_value", want.front_value, rsp.front_value);
					bad += field_differs("back_value", want.back_value, rsp.back_value);
					bad += field_differs("count", want.count, rsp.count);
				end
			end
			if (req_valid && req_ready)
				owed_answers.push_back(apply_command(req));
			if (bad != 0)
				mismatches <= mismatches + 1;
			answers_owed <= owed_answers.size();
		end
	end

endmodule

>>> test/tb_double_ended_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Drives commands into the double-ended queue: a directed pass over the
// empty, not-found and spare-code cases, then random runs biased to fill,
// drain or mix, with random gaps and response stalls. The checker beside
// the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
	import deq_pkg::*;

	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam int         RANDOM_ITEMS = 750;

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} mix_mode_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	logic steady_stretch = 1'b0;
	int   mismatches;
	int   answers_owed;

	double_ended_queue DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	deq_response_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp          (rsp),
		.mismatches   (mismatches),
		.answers_owed (answers_owed)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		rsp_ready <= steady_stretch || ($urandom_range(99) >= 6);
	end

	// Holds the request until it is taken; returns at the accepting edge
	task automatic issue_request(input logic [2:0] code, input logic [31:0] value,
			input logic [4:0] pos);
		req_t r;
		r.cmd         = cmd_t'(code);
		r.entry_value = value;
		r.position    = pos;
		while (!steady_stretch && $urandom_range(99) < 6) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
	endtask

	// Sender goes quiet until every owed response has come back
	task automatic wait_for_answers();
		req_valid <= 1'b0;
		do @(posedge clk); while (answers_owed != 0);
	endtask

	task automatic random_request(input mix_mode_t mode);
		int          pick;
		logic [2:0]  code;
		logic [31:0] value;
		pick = $urandom_range(99);
		case (mode)
			MODE_FILL:
				code = pick < 45 ? CMD_PUSH_FRONT : pick < 90 ? CMD_PUSH_BACK :
					pick < 93 ? CMD_POP_FRONT : pick < 96 ? CMD_POP_BACK : CMD_REMOVE_AT;
			MODE_DRAIN:
				code = pick < 15 ? CMD_PUSH_FRONT : pick < 30 ? CMD_PUSH_BACK :
					pick < 55 ? CMD_POP_FRONT : pick < 80 ? CMD_POP_BACK :
					pick < 98 ? CMD_REMOVE_AT : CMD_CLEAR;
			default:
				code = pick < 22 ? CMD_PUSH_FRONT : pick < 44 ? CMD_PUSH_BACK :
					pick < 60 ? CMD_POP_FRONT : pick < 76 ? CMD_POP_BACK :
					pick < 94 ? CMD_REMOVE_AT : pick < 97 ? CMD_CLEAR :
					pick < 98 ? CMD_SPARE_LO : pick < 99 ? CMD_SPARE_HI : CMD_CLEAR;
		endcase
		case ($urandom_range(15))
			0:       value = '0;
			1:       value = '1;
			default: value = $urandom();
		endcase
		issue_request(code, value, 5'($urandom_range(16)));
	endtask

	initial begin
		int        issued;
		int        run_len;
		bit        paused;
		mix_mode_t mode;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue: pops and remove report empty
		issue_request(CMD_POP_FRONT, 32'h0, 5'd0);
		issue_request(CMD_POP_BACK, 32'h0, 5'd0);
		issue_request(CMD_REMOVE_AT, 32'h0, 5'd1);
		issue_request(CMD_PUSH_BACK, 32'h0000_0000, 5'd0);
		issue_request(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 5'd31);
		issue_request(CMD_PUSH_BACK, 32'hA5A5_A5A5, 5'd0);
		issue_request(CMD_PUSH_FRONT, 32'h5A5A_5A5A, 5'd0);
		// positions zero and past the count are not found
		issue_request(CMD_REMOVE_AT, 32'h0, 5'd0);
		issue_request(CMD_REMOVE_AT, 32'h0, 5'd16);
		issue_request(CMD_REMOVE_AT, 32'h0, 5'd5);
		issue_request(CMD_REMOVE_AT, 32'h0, 5'd4);
		issue_request(CMD_REMOVE_AT, 32'h0, 5'd1);
		issue_request(CMD_REMOVE_AT, 32'h0, 5'd2);
		issue_request(CMD_SPARE_LO, 32'hDEAD_BEEF, 5'd1);
		issue_request(CMD_SPARE_HI, 32'h1234_5678, 5'd16);
		issue_request(CMD_POP_BACK, 32'h0, 5'd0);
		issue_request(CMD_PUSH_FRONT, 32'h1234_5678, 5'd0);
		issue_request(CMD_POP_FRONT, 32'h0, 5'd0);
		issue_request(CMD_PUSH_BACK, 32'h0000_0001, 5'd0);
		issue_request(CMD_CLEAR, 32'h0, 5'd0);
		issue_request(CMD_CLEAR, 32'h0, 5'd0);
		wait_for_answers();

		issued = 0;
		paused = 1'b0;
		while (issued < RANDOM_ITEMS) begin
			mode    = mix_mode_t'($urandom_range(2));
			run_len = $urandom_range(8, 40);
			for (int i = 0; i < run_len; i++) begin
				steady_stretch <= (issued >= 200 && issued < 350);
				random_request(mode);
				issued++;
			end
			if (!paused && issued >= 450) begin
				wait_for_answers();
				paused = 1'b1;
			end
		end
		steady_stretch <= 1'b0;

		wait_for_answers();
		repeat (5) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
